[hw/rtl/wasi_pkg.sv]
`default_nettype none

package wasi_pkg;

    // Width of the error marker register and of the valid count output
    localparam int MARKER_BITS = 16;
    localparam int COUNT_BITS  = 3;

    // Error marker after reset (most negative 16-bit value)
    localparam logic [MARKER_BITS-1:0] MARKER_RESET = 16'h8000;

    // Per-cycle control broadcast to every cell of the sample chain
    typedef struct packed {
        logic shift;   // load a new sample into the head, push the rest along
        logic rotate;  // move every entry one cell on, tail wraps to head
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/wasi_if.sv]
`default_nettype none

// Sample channel into the block
interface wasi_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel out of the block
interface wasi_out_if #(
    parameter int SAMPLE_BITS = 16
);
    import wasi_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic [COUNT_BITS-1:0]         valid_count;
    logic                          all_invalid;

    modport source (output valid, output average, output valid_count, output all_invalid,
                    input ready);
    modport sink   (input valid, input average, input valid_count, input all_invalid,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/wasi_cell.sv]
`default_nettype none

module wasi_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wasi_pkg::t_cell_ctl    i_ctl,
    input  wire [SAMPLE_BITS-1:0]  i_data,
    input  wire                    i_occ,
    output logic [SAMPLE_BITS-1:0] o_data,
    output logic                   o_occ
);
    import wasi_pkg::*;

    logic [SAMPLE_BITS-1:0] r_data;
    logic                   r_occ;

    // Occupancy marks a cell that has received a sample since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.shift || i_ctl.rotate) begin
            r_occ <= i_occ;
        end
    end

    // Take the neighbor's sample whenever the chain moves
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift || i_ctl.rotate) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;
    assign o_occ  = r_occ;

endmodule

`default_nettype wire

[hw/rtl/wasi_divider.sv]
`default_nettype none

module wasi_divider #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 3
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [DIVIDEND_BITS-1:0]  i_dividend,
    input  wire [DIVISOR_BITS-1:0]   i_divisor,
    output logic                     o_done,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);
    // Quotient bits resolved per cycle
    localparam int STEP   = 4;
    localparam int ROUNDS = (DIVIDEND_BITS + STEP - 1) / STEP;
    localparam int CNTW   = $clog2(ROUNDS + 1);
    // Dividend padded with leading zeros to a whole number of rounds
    localparam int PADW   = ROUNDS * STEP;

    logic [CNTW-1:0]          r_cnt;
    logic                     r_done;
    logic [PADW-1:0]          r_quo;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [PADW-1:0]          n_quo;
    logic [DIVISOR_BITS-1:0]  n_rem;

    // Restoring division, STEP bits per round
    always_comb begin
        logic [DIVISOR_BITS:0] sh;
        sh    = '0;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < STEP; k++) begin
            sh    = {n_rem, n_quo[PADW-1]};
            n_quo = {n_quo[PADW-2:0], 1'b0};
            if (sh >= {1'b0, i_divisor}) begin
                sh       = sh - {1'b0, i_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = sh[DIVISOR_BITS-1:0];
        end
    end

    // Round counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNTW'(ROUNDS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNTW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    // Dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= PADW'(i_dividend);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[DIVIDEND_BITS-1:0];

endmodule

`default_nettype wire

[hw/rtl/windowed_average_skip_invalid.sv]
`default_nettype none

// Windowed average that skips failed readings. Each transfer on i_in stores one
// signed sample in a chain of WINDOW cells (the oldest drops off the end once the
// chain is full) and produces one result on o_out: the mean of the stored samples
// that differ from the error marker, rounded to nearest with ties away from zero,
// plus the count of such samples. When no stored sample is valid the average is
// the marker and all_invalid is high. The marker is to be written by the user
// through i_cfg_we / i_cfg_data only while the block is idle; the block itself
// does not enforce this. The marker resets to -32768. Samples are handled one at
// a time: after a transfer the chain rotates once through the accumulator, then a
// radix-16 divider runs unless every stored sample is invalid, and the result is
// loaded into the output register. The next sample is taken while the previous
// result still waits in the output register.
module windowed_average_skip_invalid #(
    parameter int WINDOW      = 6,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    wasi_in_if.sink                          i_in,
    wasi_out_if.source                       o_out,
    input  wire                              i_cfg_we,
    input  wire [wasi_pkg::MARKER_BITS-1:0]  i_cfg_data
);
    import wasi_pkg::*;

    localparam int CNTW   = $clog2(WINDOW + 1);
    localparam int STEPW  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int SUMW   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIVW   = SUMW + 1;
    localparam int EXTW   = (SAMPLE_BITS > MARKER_BITS) ? SAMPLE_BITS : MARKER_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state                        r_state, n_state;
    logic [STEPW-1:0]              r_step, n_step;
    logic signed [SUMW-1:0]        r_sum, n_sum;
    logic [CNTW-1:0]               r_count, n_count;
    logic [SAMPLE_BITS-1:0]        r_avg, n_avg;
    logic                          r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_avg, n_out_avg;
    logic [COUNT_BITS-1:0]         r_out_cnt, n_out_cnt;
    logic                          r_out_none, n_out_none;
    logic [MARKER_BITS-1:0]        r_marker;

    t_cell_ctl                     w_ctl;
    logic [SAMPLE_BITS-1:0]        w_data [WINDOW];
    logic                          w_occ  [WINDOW];
    logic [SAMPLE_BITS-1:0]        w_head_data;
    logic                          w_head_occ;
    logic [EXTW-1:0]               w_marker_ext;
    logic [SAMPLE_BITS-1:0]        w_marker;
    logic                          w_good;
    logic [SUMW-1:0]               w_mag;
    logic [DIVW-1:0]               w_dividend;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [DIVW-1:0]               w_quotient;
    logic [SAMPLE_BITS-1:0]        w_q;
    logic                          w_accept;

    // Hold the error marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (i_cfg_we) begin
            r_marker <= i_cfg_data;
        end
    end

    // Marker seen at sample width: sign-extend, then cut
    assign w_marker_ext = EXTW'(signed'(r_marker));
    assign w_marker     = w_marker_ext[SAMPLE_BITS-1:0];

    assign w_accept = i_in.valid && i_in.ready;

    // Chain control: new sample at the head on transfer, wrap the tail while summing
    assign w_ctl.shift  = w_accept;
    assign w_ctl.rotate = (r_state == S_SUM);
    assign w_head_data  = w_ctl.shift ? i_in.sample : w_data[WINDOW-1];
    assign w_head_occ   = w_ctl.shift ? 1'b1        : w_occ[WINDOW-1];

    // Row of sample cells
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            wasi_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_data  (w_head_data),
                .i_occ   (w_head_occ),
                .o_data  (w_data[g]),
                .o_occ   (w_occ[g])
            );
        end else begin : g_body
            wasi_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_data  (w_data[g-1]),
                .i_occ   (w_occ[g-1]),
                .o_data  (w_data[g]),
                .o_occ   (w_occ[g])
            );
        end
    end

    // Tail entry counts when it holds a sample other than the marker
    assign w_good = w_occ[WINDOW-1] && (w_data[WINDOW-1] != w_marker);

    // Rounded magnitude: |sum| + count/2, divided by count
    assign w_mag       = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign w_dividend  = DIVW'(w_mag) + DIVW'(r_count >> 1);
    assign w_div_start = (r_state == S_PREP) && (r_count != '0);

    wasi_divider #(
        .DIVIDEND_BITS (DIVW),
        .DIVISOR_BITS  (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_q = w_quotient[SAMPLE_BITS-1:0];

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sum       = r_sum;
        n_count     = r_count;
        n_avg       = r_avg;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_cnt   = r_out_cnt;
        n_out_none  = r_out_none;

        // Drop the held result once taken
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_sum   = '0;
                    n_count = '0;
                    n_step  = STEPW'(WINDOW - 1);
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // Accumulate the tail entry as the chain turns
                if (w_good) begin
                    n_sum   = r_sum + SUMW'(signed'(w_data[WINDOW-1]));
                    n_count = r_count + CNTW'(1);
                end
                if (r_step == '0) begin
                    n_state = S_PREP;
                end else begin
                    n_step = r_step - STEPW'(1);
                end
            end
            S_PREP: begin
                if (r_count == '0) begin
                    n_avg   = w_marker;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_avg   = r_sum[SUMW-1] ? SAMPLE_BITS'(-w_q) : w_q;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Load the output register when it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_cnt   = COUNT_BITS'(r_count);
                    n_out_none  = (r_count == '0);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_step     <= n_step;
        r_sum      <= n_sum;
        r_count    <= n_count;
        r_avg      <= n_avg;
        r_out_avg  <= n_out_avg;
        r_out_cnt  <= n_out_cnt;
        r_out_none <= n_out_none;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.average     = r_out_avg;
    assign o_out.valid_count = r_out_cnt;
    assign o_out.all_invalid = r_out_none;

endmodule

`default_nettype wire
